// ===== sv/gillespie_replica_step_top_defines.svh =====
// Assertion macros shared by the replica step block.
`ifndef GILLESPIE_REPLICA_STEP_TOP_DEFINES_SVH
`define GILLESPIE_REPLICA_STEP_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define GRS_ASSERT_IMPLIES(lbl, clk, rst_n, pre, post, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define GRS_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/grs_pkg.sv =====
// Package of types, constants and codes for the replica step block.
`default_nettype none
package grs_pkg;
	localparam int REPLICAS_DEF   = 1024;
	localparam int COUNT_BITS_DEF = 16;
	localparam int REPLICA_W      = 10;
	localparam int RAND_W         = 32;
	localparam int CFG_W          = 24;
	localparam int CFG_IDX_W      = 3;
	localparam int DIV_W          = 64;
	localparam int MUL_AW         = 64;
	localparam int MUL_BW         = 33;
	localparam int MUL_PW         = MUL_AW + MUL_BW;
	localparam int FIFO_DEPTH     = 4;
	localparam int FIFO_AW        = 2;
	localparam int LOG_ITERS      = 24;
	localparam int COUNT_INIT     = 2;
	localparam logic [32:0] ONE_Q24  = 33'd16777216;
	localparam logic [59:0] RATE_MAX = 60'hFFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] LN2_Q32  = 32'd2977044472;

	typedef enum logic [2:0] {
		EVT_C_DIE  = 3'd0,
		EVT_C_BORN = 3'd1,
		EVT_D_DIE  = 3'd2,
		EVT_D_BORN = 3'd3,
		EVT_NONE   = 3'd4
	} evt_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEATH_RATE = 3'd0,
		REG_SELECTION  = 3'd1,
		REG_BONUS      = 3'd2,
		REG_BENEFIT    = 3'd3,
		REG_COST       = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [23:0] death_rate;
		logic [15:0] selection_strength;
		logic [7:0]  cooperator_bonus;
		logic [3:0]  benefit;
		logic [3:0]  cost;
	} cfg_t;

	// Queued step: replica, normalized log mantissa and exponent, pick word
	typedef struct packed {
		logic [REPLICA_W-1:0] replica;
		logic [5:0]           k;
		logic [31:0]          y;
		logic [RAND_W-1:0]    rand_pick;
	} job_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

	typedef enum logic [4:0] {
		ST_CLEAR, ST_IDLE, ST_DIV_WAIT, ST_MUL_LO, ST_MUL_HI, ST_READ, ST_LOAD,
		ST_X, ST_T1, ST_T2, ST_T3, ST_G, ST_R1, ST_R2, ST_H1, ST_A1, ST_H2,
		ST_A3, ST_ND, ST_A0, ST_A2, ST_SUM, ST_LOG, ST_NL, ST_NLD, ST_TAU,
		ST_W, ST_FIN
	} bstate_t;
endpackage
`default_nettype wire

// ===== sv/grs_intf.sv =====
// Valid/ready channel interfaces for step requests and results.
`default_nettype none
interface grs_in_if import grs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [REPLICA_W-1:0] replica;
	logic [RAND_W-1:0]    rand_time;
	logic [RAND_W-1:0]    rand_pick;
	modport source(output valid, replica, rand_time, rand_pick, input ready);
	modport sink(input valid, replica, rand_time, rand_pick, output ready);
endinterface

interface grs_out_if import grs_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [REPLICA_W-1:0] replica_out;
	logic [15:0]          cooperators;
	logic [15:0]          defectors;
	logic [63:0]          elapsed_time;
	logic [2:0]           event_res;
	logic                 saturated;
	modport source(output valid, replica_out, cooperators, defectors, elapsed_time,
		event_res, saturated, input ready);
	modport sink(input valid, replica_out, cooperators, defectors, elapsed_time,
		event_res, saturated, output ready);
endinterface
`default_nettype wire

// ===== sv/gillespie_replica_step_top.sv =====
// Gillespie replica step block: at most one stochastic event per request.
//
// in_ch carries a replica index and two uniform words; out_ch returns the
// replica's counts, time, event code and saturation flag, one result per
// request, in request order. Both are valid/ready channels; a beat moves on
// a clock edge with valid and ready high.
// Configuration registers are written through cfg_we/cfg_index/cfg_data,
// one register per cycle. The user must write them only while the block
// is idle; the block itself does not enforce this. A four-entry request
// queue lets the front end take beats back to back while the back end
// works. The back end handles one step at a time; each step uses up to
// four divisions on the shared one-bit-per-cycle divider, LOG_ITERS
// squaring iterations for the log, and multiplies split in two halves.
// After reset the replica store is swept, one entry per cycle, over all
// REPLICAS entries; in_ch.ready stays low until the sweep ends.
// When out_ch stalls, the finished result holds in its output register and
// the back end waits before publishing the next one; the queue still fills.
`default_nettype none
`include "gillespie_replica_step_top_defines.svh"
module gillespie_replica_step_top import grs_pkg::*; #(
	parameter int REPLICAS   = REPLICAS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	grs_in_if.sink                    in_ch,
	grs_out_if.source                 out_ch,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);
	cfg_t       cfg_q;
	back_stat_t stat;
	logic       job_valid;
	logic       job_take;
	job_t       job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.death_rate         <= 24'd152520;
			cfg_q.selection_strength <= 16'd6554;
			cfg_q.cooperator_bonus   <= 8'd10;
			cfg_q.benefit            <= 4'd3;
			cfg_q.cost               <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEATH_RATE: cfg_q.death_rate         <= cfg_data;
				REG_SELECTION:  cfg_q.selection_strength <= cfg_data[15:0];
				REG_BONUS:      cfg_q.cooperator_bonus   <= cfg_data[7:0];
				REG_BENEFIT:    cfg_q.benefit            <= cfg_data[3:0];
				REG_COST:       cfg_q.cost               <= cfg_data[3:0];
				default: begin
				end
			endcase
		end
	end

	grs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.stat      (stat),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take)
	);

	grs_back #(
		.REPLICAS   (REPLICAS),
		.COUNT_BITS (COUNT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (job_valid),
		.job       (job),
		.job_take  (job_take),
		.stat      (stat),
		.out_ch    (out_ch)
	);

	`GRS_ASSERT_IMPLIES(a_no_accept_clear, clk, arst_n, in_ch.valid && in_ch.ready, !stat.clearing, "beat accepted during store sweep")
	`GRS_ASSERT_IMPLIES(a_take_valid, clk, arst_n, job_take, job_valid, "back end took from empty queue")
	`GRS_ASSERT_IMPLIES(a_none_nosat, clk, arst_n, out_ch.valid && (out_ch.event_res == EVT_NONE), !out_ch.saturated, "no-event result flagged saturated")
	`GRS_ASSERT_NEXT(a_sweep_once, clk, arst_n, !stat.clearing, !stat.clearing, "store sweep restarted")
endmodule
`default_nettype wire

// ===== sv/grs_div.sv =====
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module grs_div import grs_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [DIV_W-1:0] dividend,
	input  wire logic [DIV_W-1:0] divisor,
	output logic                  done,
	output logic [DIV_W-1:0]      quot
);
	localparam int CNT_W = $clog2(DIV_W + 1);

	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DIV_W-1:0] quot_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] den_q;
	logic [DIV_W:0]   trial;
	logic [DIV_W:0]   diff;
	logic             qbit;

	always_comb begin
		trial = {rem_q, quot_q[DIV_W-1]};
		diff  = trial - {1'b0, den_q};
		qbit  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(DIV_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q <= dividend;
			rem_q  <= '0;
			den_q  <= divisor;
		end else if (run_q) begin
			quot_q <= {quot_q[DIV_W-2:0], qbit};
			rem_q  <= qbit ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
		end
	end

	assign done = done_q;
	assign quot = quot_q;
endmodule
`default_nettype wire

// ===== sv/grs_front.sv =====
// Front end: accepts steps, normalizes the time word for the log, queues jobs.
`default_nettype none
module grs_front import grs_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	grs_in_if.sink     in_ch,
	input  back_stat_t stat,
	output logic       job_valid,
	output job_t       job,
	input  wire logic  job_take
);
	job_t               fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_q;
	logic [FIFO_AW-1:0] rd_q;
	logic [FIFO_AW:0]   cnt_q;
	logic               push;
	logic               pop;
	logic [32:0]        v;
	logic [32:0]        sh;
	logic [5:0]         k;
	logic [31:0]        y;
	job_t               new_job;

	// Position of the leading one of u+1, then left-justify to a Q1.31 mantissa
	always_comb begin
		v = {1'b0, in_ch.rand_time} + 33'd1;
		k = '0;
		for (int i = 0; i < 33; i++) begin
			if (v[i]) k = 6'(i);
		end
		sh = v << (6'd31 - k);
		y  = (k == 6'd32) ? v[32:1] : sh[31:0];
		new_job.replica   = in_ch.replica;
		new_job.k         = k;
		new_job.y         = y;
		new_job.rand_pick = in_ch.rand_pick;
	end

	assign in_ch.ready = (cnt_q != (FIFO_AW+1)'(FIFO_DEPTH)) && !stat.clearing;
	assign push        = in_ch.valid && in_ch.ready;
	assign pop         = job_take && job_valid;
	assign job_valid   = (cnt_q != '0);
	assign job         = fifo_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 1'b1;
			if (pop) rd_q <= rd_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_q] <= new_job;
	end
endmodule
`default_nettype wire

// ===== sv/grs_back.sv =====
// Back end: replica store and the micro-sequenced Gillespie datapath.
`default_nettype none
module grs_back import grs_pkg::*; #(
	parameter int REPLICAS   = REPLICAS_DEF,
	parameter int COUNT_BITS = COUNT_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  cfg_t       cfg,
	input  wire logic  job_valid,
	input  job_t       job,
	output logic       job_take,
	output back_stat_t stat,
	grs_out_if.source  out_ch
);
	localparam int IDX_W = (REPLICAS > 1) ? $clog2(REPLICAS) : 1;
	localparam int CB    = COUNT_BITS;
	localparam int MW    = 2 * CB + 64;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(REPLICAS - 1);
	localparam logic [CB-1:0]    CMAX     = '1;
	localparam logic [CB-1:0]    CINIT    = CB'(COUNT_INIT);
	localparam int RED_SH = 20;
	localparam logic [31:0] RED_MUL =
		32'(((64'd1 << RED_SH) + 64'(REPLICAS) - 64'd1) / 64'(REPLICAS));

	function automatic logic [59:0] rsat(input logic [MUL_PW-1:0] p);
		return (p > MUL_PW'(RATE_MAX)) ? RATE_MAX : p[59:0];
	endfunction

	bstate_t st_q, st_d, ret_q;
	logic [IDX_W-1:0] clr_q;
	logic             ov_q;
	logic             div_go_q;
	logic             div_issue;
	logic             out_free;

	logic [MW-1:0]    mem [REPLICAS];
	logic [MW-1:0]    rd_q;
	logic             mem_we;
	logic [IDX_W-1:0] mem_wa;
	logic [IDX_W-1:0] mem_ra;
	logic [MW-1:0]    mem_wd;

	logic [DIV_W-1:0]  div_a_q, div_b_q, div_q;
	logic              div_done;
	logic [MUL_AW-1:0] ma_q;
	logic [MUL_BW-1:0] mb_q;
	logic [64:0]       plo_q;
	logic [64:0]       plo_w, phi_w;
	logic [MUL_PW-1:0] prod_q;

	job_t             job_q;
	logic [IDX_W-1:0] idx_q;
	logic [CB-1:0]    c_q, d_q;
	logic [63:0]      t_q;
	logic [CB:0]      n_q;
	logic [24:0]      x_q;
	logic [27:0]      bx_q;
	logic             neg_q;
	logic [31:0]      f1_q, f2_q, ft_q;
	logic [32:0]      g_q;
	logic [63:0]      r1_q, r2_q;
	logic [59:0]      a0_q, a1_q, a2_q, a3_q, nd_q;
	logic [61:0]      asum_q;
	logic [31:0]      y_q;
	logic [23:0]      frac_q;
	logic [4:0]       lc_q;
	logic [63:0]      tau_q;
	evt_t             ev_q;
	logic             sat_q;
	logic [CB-1:0]    rc_q, rd2_q;
	logic [63:0]      rt_q;
	logic [IDX_W-1:0] ridx_q;

	// Combinational helpers
	logic [31:0]      rq_w;
	logic [11:0]      rqe_w;
	logic [27:0]      rqd_w, rr_w;
	logic [IDX_W-1:0] red_idx_w;
	logic [CB-1:0]  ld_c, ld_d;
	logic [CB:0]    ld_n;
	logic [24:0]    x_w;
	logic [27:0]    bx_w;
	logic [29:0]    d1_w, d1m_w;
	logic [4:0]     bc_w, bcm_w;
	logic [27:0]    bcx_w;
	logic [23:0]    s_w;
	logic [31:0]    tmag_w, tsgn_w;
	logic           ok1, ok2;
	logic [61:0]    asum_w;
	logic [63:0]    sq_w;
	logic [29:0]    nl2_w;
	logic [60:0]    cum2_w;
	logic [61:0]    cum3_w;
	logic [63:0]    w_w;
	logic [64:0]    tsum_w;
	evt_t           ev_w;
	logic [CB-1:0]  nc_w, ndc_w;
	logic [63:0]    nt_w;
	logic           ns_w;

	assign plo_w = 65'(ma_q[31:0]) * 65'(mb_q);
	assign phi_w = 65'(ma_q[63:32]) * 65'(mb_q);

	always_comb begin
		// Replica index modulo REPLICAS by reciprocal multiply; the quotient
		// estimate is at most one high, so add back one modulus when it is
		rq_w      = 32'(job.replica) * RED_MUL;
		rqe_w     = rq_w[31:20];
		rqd_w     = 28'(rqe_w) * 28'(REPLICAS);
		rr_w      = (rqd_w > 28'(job.replica)) ?
			(28'(job.replica) + 28'(REPLICAS) - rqd_w) : (28'(job.replica) - rqd_w);
		red_idx_w = IDX_W'(rr_w);
		ld_c   = rd_q[MW-1:CB+64];
		ld_d   = rd_q[CB+63:64];
		ld_n   = (CB+1)'(ld_c) + (CB+1)'(ld_d);
		x_w    = div_q[24:0];
		bx_w   = 28'(x_w) * 28'(cfg.benefit);
		d1_w   = 30'(bx_w) - (30'(cfg.cost) << 24);
		d1m_w  = d1_w[29] ? (30'd0 - d1_w) : d1_w;
		bc_w   = 5'(cfg.benefit) - 5'(cfg.cost);
		bcm_w  = bc_w[4] ? (5'd0 - bc_w) : bc_w;
		bcx_w  = 28'(bcm_w) * 28'(x_q);
		s_w    = {cfg.selection_strength, 8'd0};
		// Product with S divided by 2^24, truncated toward zero
		tmag_w = prod_q[55:24];
		tsgn_w = neg_q ? (32'd0 - tmag_w) : tmag_w;
		ok1    = !f1_q[31] && (f1_q != '0) && !ft_q[31] && (ft_q != '0);
		ok2    = !f2_q[31] && (f2_q != '0) && !ft_q[31] && (ft_q != '0);
		asum_w = 62'(a0_q) + 62'(a1_q) + 62'(a2_q) + 62'(a3_q);
		sq_w   = 64'(y_q) * 64'(y_q);
		nl2_w  = {6'd32 - job_q.k, 24'd0} - 30'(frac_q);
		cum2_w = 61'(a0_q) + 61'(a1_q);
		cum3_w = 62'(cum2_w) + 62'(a2_q);
		w_w    = prod_q[95:32];
		tsum_w = 65'(t_q) + 65'(tau_q);
		priority if (w_w < 64'(a0_q)) ev_w = EVT_C_DIE;
		else if (w_w < 64'(cum2_w)) ev_w = EVT_C_BORN;
		else if (w_w < 64'(cum3_w)) ev_w = EVT_D_DIE;
		else ev_w = EVT_D_BORN;
		nc_w  = c_q;
		ndc_w = d_q;
		ns_w  = tsum_w[64];
		nt_w  = tsum_w[64] ? '1 : tsum_w[63:0];
		unique case (ev_w)
			EVT_C_DIE:  if (c_q != '0) nc_w = c_q - 1'b1;
			EVT_C_BORN: if (c_q != CMAX) nc_w = c_q + 1'b1; else ns_w = 1'b1;
			EVT_D_DIE:  if (d_q != '0) ndc_w = d_q - 1'b1;
			default:    if (d_q != CMAX) ndc_w = d_q + 1'b1; else ns_w = 1'b1;
		endcase
	end

	assign out_free  = !ov_q || out_ch.ready;
	assign job_take  = (st_q == ST_IDLE) && job_valid;
	assign stat.clearing = (st_q == ST_CLEAR);
	assign div_issue = ((st_q == ST_LOAD) && (ld_n != '0)) || ((st_q == ST_G) && ok1) ||
		((st_q == ST_R1) && ok2) || (st_q == ST_NLD);

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_CLEAR:    if (clr_q == LAST_IDX) st_d = ST_IDLE;
			ST_IDLE:     if (job_valid) st_d = ST_READ;
			ST_DIV_WAIT: if (div_done) st_d = ret_q;
			ST_MUL_LO:   st_d = ST_MUL_HI;
			ST_MUL_HI:   st_d = ret_q;
			ST_READ:     st_d = ST_LOAD;
			ST_LOAD:     st_d = (ld_n == '0) ? ST_FIN : ST_DIV_WAIT;
			ST_G:        st_d = ok1 ? ST_DIV_WAIT : ST_R1;
			ST_R1:       st_d = ok2 ? ST_DIV_WAIT : ST_R2;
			ST_A2:       st_d = ST_SUM;
			ST_SUM:      st_d = (asum_w == '0) ? ST_FIN : ST_LOG;
			ST_LOG:      if (lc_q == 5'(LOG_ITERS - 1)) st_d = ST_NL;
			ST_NLD:      st_d = ST_DIV_WAIT;
			ST_W:        st_d = ST_FIN;
			ST_FIN:      if (out_free) st_d = ST_IDLE;
			default:     st_d = ST_MUL_LO;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= ST_CLEAR;
			clr_q    <= '0;
			ov_q     <= 1'b0;
			div_go_q <= 1'b0;
		end else begin
			st_q     <= st_d;
			div_go_q <= div_issue;
			if (st_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			if (ov_q && out_ch.ready) ov_q <= 1'b0;
			if ((st_q == ST_FIN) && out_free) ov_q <= 1'b1;
		end
	end

	// Replica store: one write port, one registered read port
	always_comb begin
		mem_we = (st_q == ST_CLEAR) || (st_q == ST_W);
		mem_wa = (st_q == ST_CLEAR) ? clr_q : idx_q;
		mem_wd = (st_q == ST_CLEAR) ? {CINIT, CINIT, 64'd0} : {nc_w, ndc_w, nt_w};
		mem_ra = idx_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
	end

	grs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_go_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.done     (div_done),
		.quot     (div_q)
	);

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				job_q <= job;
				idx_q <= red_idx_w;
			end
			ST_MUL_LO: plo_q <= plo_w;
			ST_MUL_HI: prod_q <= {phi_w, 32'd0} + MUL_PW'(plo_q);
			ST_LOAD: begin
				c_q     <= ld_c;
				d_q     <= ld_d;
				t_q     <= rd_q[63:0];
				n_q     <= ld_n;
				ev_q    <= EVT_NONE;
				sat_q   <= 1'b0;
				ret_q   <= ST_X;
				div_a_q <= 64'(ld_c) << 24;
				div_b_q <= 64'(ld_n);
			end
			ST_X: begin
				x_q   <= x_w;
				bx_q  <= bx_w;
				neg_q <= d1_w[29];
				ma_q  <= 64'(d1m_w);
				mb_q  <= 33'(s_w);
				ret_q <= ST_T1;
			end
			ST_T1: begin
				f1_q  <= 32'(ONE_Q24) + tsgn_w;
				neg_q <= 1'b0;
				ma_q  <= 64'(bx_q);
				mb_q  <= 33'(s_w);
				ret_q <= ST_T2;
			end
			ST_T2: begin
				f2_q  <= 32'(ONE_Q24) + tsgn_w;
				neg_q <= bc_w[4];
				ma_q  <= 64'(bcx_w);
				mb_q  <= 33'(s_w);
				ret_q <= ST_T3;
			end
			ST_T3: begin
				ft_q  <= 32'(ONE_Q24) + tsgn_w;
				ma_q  <= 64'(x_q);
				mb_q  <= 33'(cfg.cooperator_bonus);
				ret_q <= ST_G;
			end
			ST_G: begin
				g_q     <= ONE_Q24 + prod_q[32:0];
				ret_q   <= ST_R1;
				div_a_q <= 64'(f1_q) << 24;
				div_b_q <= 64'(ft_q);
			end
			ST_R1: begin
				r1_q    <= ok1 ? div_q : '0;
				ret_q   <= ST_R2;
				div_a_q <= 64'(f2_q) << 24;
				div_b_q <= 64'(ft_q);
			end
			ST_R2: begin
				r2_q  <= ok2 ? div_q : '0;
				ma_q  <= r1_q;
				mb_q  <= g_q;
				ret_q <= ST_H1;
			end
			ST_H1: begin
				ma_q  <= prod_q[87:24];
				mb_q  <= 33'(c_q);
				ret_q <= ST_A1;
			end
			ST_A1: begin
				a1_q  <= rsat(prod_q);
				ma_q  <= r2_q;
				mb_q  <= g_q;
				ret_q <= ST_H2;
			end
			ST_H2: begin
				ma_q  <= prod_q[87:24];
				mb_q  <= 33'(d_q);
				ret_q <= ST_A3;
			end
			ST_A3: begin
				a3_q  <= rsat(prod_q);
				ma_q  <= 64'(n_q);
				mb_q  <= 33'(cfg.death_rate);
				ret_q <= ST_ND;
			end
			ST_ND: begin
				nd_q  <= rsat(prod_q);
				ma_q  <= 64'(rsat(prod_q));
				mb_q  <= 33'(c_q);
				ret_q <= ST_A0;
			end
			ST_A0: begin
				a0_q  <= rsat(prod_q);
				ma_q  <= 64'(nd_q);
				mb_q  <= 33'(d_q);
				ret_q <= ST_A2;
			end
			ST_A2: a2_q <= rsat(prod_q);
			ST_SUM: begin
				asum_q <= asum_w;
				y_q    <= job_q.y;
				frac_q <= '0;
				lc_q   <= '0;
			end
			ST_LOG: begin
				// One squaring per cycle; a carry past 2.0 yields a one bit
				lc_q <= lc_q + 1'b1;
				if (sq_w[63]) begin
					y_q    <= sq_w[63:32];
					frac_q <= {frac_q[22:0], 1'b1};
				end else begin
					y_q    <= sq_w[62:31];
					frac_q <= {frac_q[22:0], 1'b0};
				end
			end
			ST_NL: begin
				ma_q  <= 64'(nl2_w);
				mb_q  <= 33'(LN2_Q32);
				ret_q <= ST_NLD;
			end
			ST_NLD: begin
				ret_q   <= ST_TAU;
				div_a_q <= 64'(prod_q[61:32]) << 24;
				div_b_q <= 64'(asum_q);
			end
			ST_TAU: begin
				tau_q <= div_q;
				ma_q  <= 64'(asum_q);
				mb_q  <= 33'(job_q.rand_pick);
				ret_q <= ST_W;
			end
			ST_W: begin
				c_q   <= nc_w;
				d_q   <= ndc_w;
				t_q   <= nt_w;
				ev_q  <= ev_w;
				sat_q <= ns_w;
			end
			ST_FIN: begin
				if (out_free) begin
					rc_q   <= c_q;
					rd2_q  <= d_q;
					rt_q   <= t_q;
					ridx_q <= idx_q;
				end
			end
			default: begin
			end
		endcase
	end

	logic [2:0] rev_q;
	logic       rsat_q;
	always_ff @(posedge clk) begin
		if ((st_q == ST_FIN) && out_free) begin
			rev_q  <= ev_q;
			rsat_q <= sat_q;
		end
	end

	assign out_ch.valid        = ov_q;
	assign out_ch.replica_out  = REPLICA_W'(ridx_q);
	assign out_ch.cooperators  = 16'(rc_q);
	assign out_ch.defectors    = 16'(rd2_q);
	assign out_ch.elapsed_time = rt_q;
	assign out_ch.event_res    = rev_q;
	assign out_ch.saturated    = rsat_q;
endmodule
`default_nettype wire
